// ===== rtl/cpose_pkg.sv =====
// Shared types, constants and tables for the corner pose engine.
`timescale 1ns / 1ps
package cpose_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 18;
  localparam int FIFO_DEPTH_DEF   = 4;   // power of two

  // divider: one overflow check stage plus one stage per quotient bit
  localparam int QUO_BITS = 32;
  localparam int DIV_LAT  = QUO_BITS + 1;

  localparam int NORM_STAGES = 6;        // shift steps 32,16,8,4,2,1
  localparam int CW = 45;                // cordic x/y width
  localparam int ZW = 36;                // cordic angle width, Q30
  localparam longint PI_Q30 = 64'd3373259426;
  localparam int YAW_W = 19;
  localparam logic [31:0] DET_THR_RST = 32'd4295;

  typedef struct packed {
    logic               par;
    logic               negx;
    logic               negy;
    logic [63:0]        nmx;
    logic [63:0]        nmy;
    logic [63:0]        dmag;
    logic signed [31:0] ha;
    logic signed [31:0] hb;
  } front_item_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = ZW'(843314857);
      1:  v = ZW'(497837829);
      2:  v = ZW'(263043837);
      3:  v = ZW'(133525159);
      4:  v = ZW'(67021687);
      5:  v = ZW'(33543516);
      6:  v = ZW'(16775851);
      7:  v = ZW'(8388437);
      8:  v = ZW'(4194283);
      9:  v = ZW'(2097149);
      10: v = ZW'(1048576);
      11: v = ZW'(524288);
      12: v = ZW'(262144);
      13: v = ZW'(131072);
      14: v = ZW'(65536);
      15: v = ZW'(32768);
      16: v = ZW'(16384);
      17: v = ZW'(8192);
      18: v = ZW'(4096);
      19: v = ZW'(2048);
      20: v = ZW'(1024);
      21: v = ZW'(512);
      22: v = ZW'(256);
      23: v = ZW'(128);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/cpose_fifo.sv =====
// Small register queue between the front and back pipelines.
`timescale 1ns / 1ps
module cpose_fifo
  import cpose_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  front_item_t data_i,
  output logic        full_o,
  input  logic        pop_i,
  output front_item_t data_o,
  output logic        empty_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  front_item_t     mem_q [DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CNTW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + PW'(1);
      if (do_pop)  rd_q <= rd_q + PW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CNTW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

// ===== rtl/cpose_front.sv =====
// Front pipeline: products, determinant, parallel test and heading line pick.
`timescale 1ns / 1ps
module cpose_front
  import cpose_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic signed [31:0] a1_i,
  input  logic signed [31:0] b1_i,
  input  logic signed [31:0] c1_i,
  input  logic signed [31:0] a2_i,
  input  logic signed [31:0] b2_i,
  input  logic signed [31:0] c2_i,
  input  logic [31:0]        det_thr_i,
  output logic               item_valid_o,
  output front_item_t        item_o,
  input  logic               q_full_i
);
  logic [3:0] vld_q;
  logic       adv;

  // stage 0: captured inputs
  logic signed [31:0] a1_q, b1_q, c1_q, a2_q, b2_q, c2_q;
  // stage 1: products and chosen heading line
  logic signed [63:0] p_a1b2_q, p_a2b1_q, p_b1c2_q, p_b2c1_q, p_a2c1_q, p_a1c2_q;
  logic signed [31:0] ha1_q, hb1_q;
  // stage 2: determinant and numerators
  logic signed [64:0] det_q, numx_q, numy_q;
  logic signed [31:0] ha2_q, hb2_q;
  // stage 3
  front_item_t        item_q;

  logic               horiz;
  logic signed [32:0] neg_a1;
  logic signed [64:0] abs_det, abs_nx, abs_ny;
  logic [63:0]        dmag;

  assign adv          = !vld_q[3] || !q_full_i;
  assign full_o       = !adv;
  assign item_valid_o = vld_q[3];
  assign item_o       = item_q;

  // line one is the horizontal wall when -a1 > 0 and -a1 > b1
  assign neg_a1 = -33'(a1_q);
  assign horiz  = a1_q[31] && (neg_a1 > 33'(b1_q));

  assign abs_det = det_q[64]  ? -det_q  : det_q;
  assign abs_nx  = numx_q[64] ? -numx_q : numx_q;
  assign abs_ny  = numy_q[64] ? -numy_q : numy_q;
  assign dmag    = abs_det[63:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[2:0], push_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a1_q <= a1_i; b1_q <= b1_i; c1_q <= c1_i;
      a2_q <= a2_i; b2_q <= b2_i; c2_q <= c2_i;

      p_a1b2_q <= a1_q * b2_q;
      p_a2b1_q <= a2_q * b1_q;
      p_b1c2_q <= b1_q * c2_q;
      p_b2c1_q <= b2_q * c1_q;
      p_a2c1_q <= a2_q * c1_q;
      p_a1c2_q <= a1_q * c2_q;
      ha1_q    <= horiz ? a1_q : a2_q;
      hb1_q    <= horiz ? b1_q : b2_q;

      det_q  <= 65'(p_a1b2_q) - 65'(p_a2b1_q);
      numx_q <= 65'(p_b1c2_q) - 65'(p_b2c1_q);
      numy_q <= 65'(p_a2c1_q) - 65'(p_a1c2_q);
      ha2_q  <= ha1_q;
      hb2_q  <= hb1_q;

      item_q.par  <= (dmag == '0) || (dmag < 64'(det_thr_i));
      item_q.negx <= (numx_q[64] == det_q[64]);
      item_q.negy <= (numy_q[64] == det_q[64]);
      item_q.nmx  <= abs_nx[63:0];
      item_q.nmy  <= abs_ny[63:0];
      item_q.dmag <= dmag;
      item_q.ha   <= ha2_q;
      item_q.hb   <= hb2_q;
    end
  end

endmodule

// ===== rtl/cpose_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
`timescale 1ns / 1ps
module cpose_div
  import cpose_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [63:0]         num_i,
  input  logic [63:0]         den_i,
  output logic [QUO_BITS-1:0] quo_o,
  output logic                big_o
);
  localparam int RW = 64 + QUO_BITS;

  logic [RW-1:0]       rem_q [QUO_BITS];
  logic [63:0]         den_q [QUO_BITS];
  logic [QUO_BITS-1:0] quo_q [QUO_BITS+1];
  logic                big_q [QUO_BITS+1];

  assign quo_o = quo_q[QUO_BITS];
  assign big_o = big_q[QUO_BITS];

  // big: quotient would not fit in QUO_BITS bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= RW'(num_i) << FRAC_BITS;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      big_q[0] <= RW'(num_i) >= (RW'(den_i) << (QUO_BITS - FRAC_BITS));
    end
  end

  for (genvar j = 0; j < QUO_BITS; j++) begin : g_stage
    localparam int SH = QUO_BITS - 1 - j;
    logic [RW-1:0] dsh;
    logic          ge;
    assign dsh = RW'(den_q[j]) << SH;
    assign ge  = rem_q[j] >= dsh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[j+1] <= quo_q[j] | (ge ? (QUO_BITS'(1) << SH) : '0);
        big_q[j+1] <= big_q[j];
      end
    end

    if (j < QUO_BITS - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j+1] <= ge ? rem_q[j] - dsh : rem_q[j];
          den_q[j+1] <= den_q[j];
        end
      end
    end
  end

endmodule

// ===== rtl/cpose_cordic.sv =====
// Pipelined vectoring CORDIC giving atan2(a, -b) in fixed-point radians.
`timescale 1ns / 1ps
module cpose_cordic
  import cpose_pkg::*;
#(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [31:0]      a_i,
  input  logic signed [31:0]      b_i,
  output logic signed [YAW_W-1:0] yaw_o
);
  localparam int NS = 1 + NORM_STAGES + CORDIC_STEPS;   // stages holding x/y/z
  localparam int SR = 30 - FRAC_BITS;
  localparam longint PI_F = (PI_Q30 + (64'd1 << (SR - 1))) >> SR;
  localparam logic signed [ZW-1:0] PI_FZ = ZW'(PI_F);
  localparam logic signed [ZW-1:0] PI_Z  = ZW'(PI_Q30);

  logic signed [CW-1:0] x_q [NS];
  logic signed [CW-1:0] y_q [NS];
  logic signed [ZW-1:0] z_q [NS];
  logic                 deg_q [NS];   // a == 0: no rotation needed
  logic                 dpi_q [NS];   // degenerate answer is pi
  logic signed [ZW-1:0] yaw_q;

  logic signed [CW-1:0] x0, y0;
  logic signed [ZW-1:0] zr, rnd;

  assign y0 = CW'(a_i);
  assign x0 = -CW'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      deg_q[0] <= (a_i == '0);
      dpi_q[0] <= !(x0 > 0);
      if (x0 < 0) begin
        x_q[0] <= -x0;
        y_q[0] <= -y0;
        z_q[0] <= (y0 > 0) ? PI_Z : -PI_Z;
      end else begin
        x_q[0] <= x0;
        y_q[0] <= y0;
        z_q[0] <= '0;
      end
    end
  end

  // normalize: largest shift keeping x and |y| below 2^40 before the last doubling
  for (genvar j = 0; j < NORM_STAGES; j++) begin : g_norm
    localparam int K = 32 >> j;
    localparam logic signed [CW-1:0] LIM = CW'(1) <<< (41 - K);
    logic fits;
    assign fits = (x_q[j] < LIM) && (y_q[j] < LIM) && (y_q[j] > -LIM);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[j+1]   <= fits ? (x_q[j] <<< K) : x_q[j];
        y_q[j+1]   <= fits ? (y_q[j] <<< K) : y_q[j];
        z_q[j+1]   <= z_q[j];
        deg_q[j+1] <= deg_q[j];
        dpi_q[j+1] <= dpi_q[j];
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    localparam int N = 1 + NORM_STAGES + i;
    localparam logic signed [ZW-1:0] ATN = atan_q30(i);
    logic signed [CW-1:0] dx, dy;
    assign dx = y_q[N-1] >>> i;
    assign dy = x_q[N-1] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[N-1] > 0) begin
          x_q[N] <= x_q[N-1] + dx;
          y_q[N] <= y_q[N-1] - dy;
          z_q[N] <= z_q[N-1] + ATN;
        end else begin
          x_q[N] <= x_q[N-1] - dx;
          y_q[N] <= y_q[N-1] + dy;
          z_q[N] <= z_q[N-1] - ATN;
        end
        deg_q[N] <= deg_q[N-1];
        dpi_q[N] <= dpi_q[N-1];
      end
    end
  end

  // round half up to FRAC_BITS, clamp to [-pi, pi]
  assign zr  = z_q[NS-1] + (ZW'(1) <<< (SR - 1));
  assign rnd = zr >>> SR;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (deg_q[NS-1])     yaw_q <= dpi_q[NS-1] ? PI_FZ : '0;
      else if (rnd > PI_FZ)  yaw_q <= PI_FZ;
      else if (rnd < -PI_FZ) yaw_q <= -PI_FZ;
      else                   yaw_q <= rnd;
    end
  end

  assign yaw_o = yaw_q[YAW_W-1:0];

endmodule

// ===== rtl/cpose_back.sv =====
// Back pipeline: two dividers and the heading CORDIC, aligned, then saturation.
`timescale 1ns / 1ps
module cpose_back
  import cpose_pkg::*;
#(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    item_valid_i,
  input  front_item_t             item_i,
  output logic                    item_pop_o,
  input  logic                    pop_i,
  output logic                    empty_o,
  output logic                    is_parallel_o,
  output logic signed [31:0]      robot_x_o,
  output logic signed [31:0]      robot_y_o,
  output logic signed [YAW_W-1:0] robot_yaw_o,
  output logic                    overflowed_o
);
  localparam int COR_LAT = CORDIC_STEPS + NORM_STAGES + 2;
  localparam int PAD     = DIV_LAT - COR_LAT;

  typedef struct packed {
    logic par;
    logic negx;
    logic negy;
  } flags_t;

  logic                    adv;
  logic [DIV_LAT:0]        vld_q;
  flags_t                  flg_q [DIV_LAT+1];
  logic [QUO_BITS-1:0]     qx, qy;
  logic                    bigx, bigy;
  logic signed [YAW_W-1:0] yaw_c;
  logic signed [YAW_W-1:0] yaw_dly_q [PAD+1];

  logic                    out_vld_q, par_q, ovf_q;
  logic signed [31:0]      rx_q, ry_q;
  logic signed [YAW_W-1:0] yaw_q;

  logic signed [31:0]      rx, ry;
  logic                    ovx, ovy;
  flags_t                  fl;

  // whole pipe holds while a result waits in the output register
  assign adv        = !out_vld_q || pop_i;
  assign item_pop_o = adv && item_valid_i;

  cpose_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk_i, .en_i(adv), .num_i(item_i.nmx), .den_i(item_i.dmag),
    .quo_o(qx), .big_o(bigx)
  );

  cpose_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk_i, .en_i(adv), .num_i(item_i.nmy), .den_i(item_i.dmag),
    .quo_o(qy), .big_o(bigy)
  );

  cpose_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i, .en_i(adv), .a_i(item_i.ha), .b_i(item_i.hb), .yaw_o(yaw_c)
  );

  assign yaw_dly_q[0] = yaw_c;
  for (genvar p = 0; p < PAD; p++) begin : g_pad
    always_ff @(posedge clk_i) begin
      if (adv) yaw_dly_q[p+1] <= yaw_dly_q[p];
    end
  end

  assign flg_q[0] = '{par: item_i.par, negx: item_i.negx, negy: item_i.negy};
  assign vld_q[0] = item_valid_i;
  for (genvar s = 0; s < DIV_LAT; s++) begin : g_flags
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (adv) begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) flg_q[s+1] <= flg_q[s];
    end
  end

  // sign and saturate; a quotient of 2^31 still fits as the negative bound
  always_comb begin
    fl  = flg_q[DIV_LAT];
    ovx = 1'b0;
    ovy = 1'b0;
    if (fl.negx) begin
      ovx = bigx || (qx > (QUO_BITS'(1) << (QUO_BITS - 1)));
      rx  = ovx ? 32'sh8000_0000 : -$signed(qx);
    end else begin
      ovx = bigx || qx[QUO_BITS-1];
      rx  = ovx ? 32'sh7fff_ffff : $signed(qx);
    end
    if (fl.negy) begin
      ovy = bigy || (qy > (QUO_BITS'(1) << (QUO_BITS - 1)));
      ry  = ovy ? 32'sh8000_0000 : -$signed(qy);
    end else begin
      ovy = bigy || qy[QUO_BITS-1];
      ry  = ovy ? 32'sh7fff_ffff : $signed(qy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[DIV_LAT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      par_q <= fl.par;
      rx_q  <= fl.par ? '0 : rx;
      ry_q  <= fl.par ? '0 : ry;
      yaw_q <= fl.par ? '0 : yaw_dly_q[PAD];
      ovf_q <= !fl.par && (ovx || ovy);
    end
  end

  assign empty_o       = !out_vld_q;
  assign is_parallel_o = par_q;
  assign robot_x_o     = rx_q;
  assign robot_y_o     = ry_q;
  assign robot_yaw_o   = yaw_q;
  assign overflowed_o  = ovf_q;

endmodule

// ===== rtl/corner_pose_from_two_lines.sv =====
// Robot corner pose from two wall lines: position by division, heading by CORDIC.
// Throughput: one line pair per cycle while pop keeps up; no loop limits the rate.
// Path: from the accepting edge through 3 more front stages, the queue write, 33 divider
//   stages and the output register to the result shown; the CORDIC runs alongside.
// Reset: asynchronous active low; clears all valid flags, empties the queue and
//   loads det_threshold with 4295. Payload registers are not reset.
`timescale 1ns / 1ps
module corner_pose_from_two_lines
  import cpose_pkg::*;
#(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,     // 8..24
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,  // 12..24
  parameter int FIFO_DEPTH   = FIFO_DEPTH_DEF     // power of two
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration: det_threshold
  input  logic                    cfg_we_i,
  input  logic [31:0]             cfg_wdata_i,
  // input beats
  input  logic                    push_i,
  output logic                    full_o,
  input  logic signed [31:0]      first_line_a_i,
  input  logic signed [31:0]      first_line_b_i,
  input  logic signed [31:0]      first_line_c_i,
  input  logic signed [31:0]      second_line_a_i,
  input  logic signed [31:0]      second_line_b_i,
  input  logic signed [31:0]      second_line_c_i,
  // result beats
  output logic                    empty_o,
  input  logic                    pop_i,
  output logic                    is_parallel_o,
  output logic signed [31:0]      robot_x_o,
  output logic signed [31:0]      robot_y_o,
  output logic signed [YAW_W-1:0] robot_yaw_o,
  output logic                    overflowed_o
);
  logic [31:0] det_thr_q;

  // front -> queue
  logic        f_valid;
  front_item_t f_item;
  logic        q_full;
  // queue -> back
  logic        q_empty;
  front_item_t q_item;
  logic        q_pop;

  // threshold on |det|, in units of 2^-(2*FRAC_BITS)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_thr_q <= DET_THR_RST;
    end else if (cfg_we_i) begin
      det_thr_q <= cfg_wdata_i;
    end
  end

  // Front: products, determinant, parallel decision and which line sets the
  // heading. Stalls only when the queue is full.
  cpose_front u_front (
    .clk_i, .rst_ni,
    .push_i, .full_o,
    .a1_i(first_line_a_i),  .b1_i(first_line_b_i),  .c1_i(first_line_c_i),
    .a2_i(second_line_a_i), .b2_i(second_line_b_i), .c2_i(second_line_c_i),
    .det_thr_i(det_thr_q),
    .item_valid_o(f_valid), .item_o(f_item), .q_full_i(q_full)
  );

  // Decouples front and back so each can hold on its own.
  cpose_fifo #(.DEPTH(FIFO_DEPTH)) u_queue (
    .clk_i, .rst_ni,
    .push_i(f_valid), .data_i(f_item), .full_o(q_full),
    .pop_i(q_pop), .data_o(q_item), .empty_o(q_empty)
  );

  // Back: quotients and heading, then sign, saturation and the output register.
  cpose_back #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk_i, .rst_ni,
    .item_valid_i(!q_empty), .item_i(q_item), .item_pop_o(q_pop),
    .pop_i, .empty_o,
    .is_parallel_o, .robot_x_o, .robot_y_o, .robot_yaw_o, .overflowed_o
  );

endmodule
